// ===== rtl/mfl_pkg.sv =====
// Package for the most-frequent-letter finder: item types, letter decode,
// scan control struct and controller states. No dependencies.
`default_nettype none

package mfl_pkg;

  localparam int NUM_LETTERS     = 26;
  localparam int LETTER_W        = $clog2(NUM_LETTERS);
  localparam int CHAR_W          = 8;
  localparam int COUNT_WIDTH_DEF = 20;

  localparam logic [CHAR_W-1:0] ASCII_UP_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_UP_Z = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LO_A = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LO_Z = 8'd122;

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);

  // Input item: one byte plus end-of-word mark
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } mfl_in_t;

  // Result item
  typedef struct packed {
    logic [LETTER_W-1:0] letter_index;
    logic                is_tie;
  } mfl_out_t;

  // Decoded byte
  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] idx;
  } mfl_letter_t;

  // Controls from the sequencer to the mode tracker
  typedef struct packed {
    logic                sample;
    logic                first;
    logic [LETTER_W-1:0] idx;
  } mfl_scan_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } mfl_state_t;

  // Fold case; non-letters give hit = 0 and index 0
  function automatic mfl_letter_t letter_decode(input logic [CHAR_W-1:0] c);
    mfl_letter_t r;
    r = '0;
    if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(c - ASCII_UP_A);
    end else if (c >= ASCII_LO_A && c <= ASCII_LO_Z) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(c - ASCII_LO_A);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mfl_ram.sv =====
// Counter memory: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module mfl_ram #(
  parameter int DEPTH = 26,
  parameter int WIDTH = 20,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mfl_mode.sv =====
// Mode tracker: walks the counts one per cycle while sample is set and keeps the largest count,
// its letter and whether more than one letter holds it. Uses mfl_pkg.
`default_nettype none

module mfl_mode #(
  parameter int CW = mfl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mfl_pkg::mfl_scan_ctl_t         ctl,
  input  logic [CW-1:0]                  count,
  output logic [mfl_pkg::LETTER_W-1:0]   best_idx,
  output logic                           tie
);
  import mfl_pkg::*;

  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_ONE  = 2'd1;
  localparam logic [1:0] HOLD_MANY = 2'd2;

  logic [CW-1:0]       best_r, best_nxt, base_best;
  logic [LETTER_W-1:0] idx_r, idx_nxt;
  logic [1:0]          hold_r, hold_nxt, base_hold;

  // compare the sampled count against the running maximum
  always_comb begin
    base_best = ctl.first ? '0 : best_r;
    base_hold = ctl.first ? HOLD_NONE : hold_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    hold_nxt  = hold_r;
    if (ctl.sample) begin
      best_nxt = base_best;
      idx_nxt  = ctl.first ? ctl.idx : idx_r;
      if (count > base_best) begin
        best_nxt = count;
        idx_nxt  = ctl.idx;
        hold_nxt = HOLD_ONE;
      end else if (count == base_best) begin
        hold_nxt = (base_hold == HOLD_NONE) ? HOLD_ONE : HOLD_MANY;
      end else begin
        hold_nxt = base_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_NONE;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    idx_r  <= idx_nxt;
  end

  assign best_idx = idx_r;
  assign tie      = (hold_r != HOLD_ONE);

endmodule

`default_nettype wire

// ===== rtl/most_frequent_letter_finder.sv =====
// Most-frequent-letter finder: letter counts in a 26-entry memory, updated
// by read-modify-write with write forwarding; a scan finds the mode.
// Letter bytes are taken one per cycle unless a scan or result is pending;
// each counter update is written from the update stage register. On a last
// byte a scan walks all counts through the single memory read port, and no
// byte is taken until the result is loaded. Reset and each result clear all counts.
`default_nettype none

module most_frequent_letter_finder #(
  parameter int COUNT_WIDTH = mfl_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfl_pkg::mfl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfl_pkg::mfl_out_t out_data
);
  import mfl_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  mfl_state_t          state_r, state_nxt;
  logic [LETTER_W-1:0] scan_idx_r, scan_idx_nxt;
  logic                load_out;

  mfl_letter_t         dec;
  logic                in_acc;
  logic [LETTER_W-1:0] rd_addr;

  // update stage
  logic                p1_v_r, p1_hit_r, p1_last_r;
  logic [LETTER_W-1:0] p1_idx_r;

  // scan sample stage
  logic                sc_v_r;
  logic [LETTER_W-1:0] sc_idx_r;

  // memory and valid bits
  logic [COUNT_WIDTH-1:0] mem_q, rd_cnt, cur_cnt, wr_data;
  logic [NUM_LETTERS-1:0] cnt_vld_r;
  logic                   vld_q_r;
  logic                   wr_en;

  // last write, for forwarding
  logic                   wr_v_r;
  logic [LETTER_W-1:0]    wr_addr_r;
  logic [COUNT_WIDTH-1:0] wr_data_r;

  mfl_scan_ctl_t       ctl;
  logic [LETTER_W-1:0] best_idx;
  logic                tie;

  logic                out_valid_r, out_valid_nxt;
  mfl_out_t            out_data_r, out_data_nxt;

  // input side
  assign dec      = letter_decode(in_data.char_code);
  assign in_stall = (state_r != ST_RUN) || (p1_v_r && p1_last_r);
  assign in_acc   = in_valid && !in_stall;
  assign rd_addr  = (state_r == ST_RUN) ? dec.idx : scan_idx_r;

  mfl_ram #(
    .DEPTH(NUM_LETTERS),
    .WIDTH(COUNT_WIDTH),
    .AW   (LETTER_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(p1_idx_r),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(mem_q)
  );

  // counter update with forwarding of the previous write
  always_comb begin
    rd_cnt  = vld_q_r ? mem_q : '0;
    cur_cnt = (wr_v_r && (wr_addr_r == p1_idx_r)) ? wr_data_r : rd_cnt;
    wr_data = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
    wr_en   = p1_v_r && p1_hit_r;
  end

  // scan sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    load_out     = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (p1_v_r && p1_last_r) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_LETTER) begin
          state_nxt    = ST_DRAIN;
          scan_idx_nxt = '0;
        end else begin
          scan_idx_nxt = scan_idx_r + LETTER_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  assign ctl.sample = sc_v_r;
  assign ctl.first  = (sc_idx_r == '0);
  assign ctl.idx    = sc_idx_r;

  mfl_mode #(
    .CW(COUNT_WIDTH)
  ) u_mode (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .count   (rd_cnt),
    .best_idx(best_idx),
    .tie     (tie)
  );

  // output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.is_tie       = tie;
      out_data_nxt.letter_index = tie ? '0 : best_idx;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      scan_idx_r  <= '0;
      p1_v_r      <= 1'b0;
      sc_v_r      <= 1'b0;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      p1_v_r      <= in_acc;
      sc_v_r      <= (state_r == ST_SCAN);
      wr_v_r      <= wr_en;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        cnt_vld_r <= '0;
      end else if (wr_en) begin
        cnt_vld_r[p1_idx_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_hit_r   <= dec.hit;
    p1_idx_r   <= dec.idx;
    p1_last_r  <= in_data.is_last;
    sc_idx_r   <= scan_idx_r;
    vld_q_r    <= cnt_vld_r[rd_addr];
    wr_addr_r  <= p1_idx_r;
    wr_data_r  <= wr_data;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/mfl_checker.sv =====
// Port-level checks for the most-frequent-letter finder, bound to the top.
// Uses mfl_pkg.
`default_nettype none

module mfl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input mfl_pkg::mfl_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input mfl_pkg::mfl_out_t out_data
);
  import mfl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a tie reports letter zero
  a_tie_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_tie |-> out_data.letter_index == '0)
    else $error("tie with nonzero letter");

  // letter index stays in the alphabet
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.letter_index <= LAST_LETTER)
    else $error("letter index out of range");

  // the block goes busy right after the end of a word
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.is_last |=> in_stall)
    else $error("byte taken during mode scan");

endmodule

bind most_frequent_letter_finder mfl_checker u_mfl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// ===== dv/letter_mode_checker.sv =====
// Checker for the most-frequent-letter finder. It watches the input and result
// item channels, keeps its own letter tallies and compares every result item.
// Depends on mfl_pkg for the item types and the ASCII bounds.
module letter_mode_checker #(
  parameter int CNT_W = mfl_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  mfl_pkg::mfl_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  mfl_pkg::mfl_out_t out_data,
  output int                errors,
  output int                pending
);

  localparam logic [CNT_W-1:0] TALLY_MAX = '1;

  // Per-letter tallies of the word in flight
  logic [CNT_W-1:0]  tally [mfl_pkg::NUM_LETTERS];
  mfl_pkg::mfl_out_t expected_modes [$];
  mfl_pkg::mfl_out_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // One line per mismatch
  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // Fold case and bump the letter's tally; it holds at its top value
  task automatic tally_byte(input logic [7:0] c);
    int idx;
    idx = -1;
    if (c >= mfl_pkg::ASCII_UP_A && c <= mfl_pkg::ASCII_UP_Z) begin
      idx = int'(c) - int'(mfl_pkg::ASCII_UP_A);
    end else if (c >= mfl_pkg::ASCII_LO_A && c <= mfl_pkg::ASCII_LO_Z) begin
      idx = int'(c) - int'(mfl_pkg::ASCII_LO_A);
    end
    if (idx >= 0 && tally[idx] != TALLY_MAX) begin
      tally[idx] = tally[idx] + 1'b1;
    end
  endtask

  // Mode of the current tallies; several holders or an empty word is a tie
  function automatic mfl_pkg::mfl_out_t tally_mode();
    logic [CNT_W-1:0]  top;
    int                top_idx;
    int                holders;
    mfl_pkg::mfl_out_t r;
    top     = '0;
    top_idx = 0;
    holders = 0;
    for (int i = 0; i < mfl_pkg::NUM_LETTERS; i++) begin
      if (tally[i] > top) begin
        top     = tally[i];
        top_idx = i;
      end
    end
    for (int i = 0; i < mfl_pkg::NUM_LETTERS; i++) begin
      if (tally[i] == top) holders++;
    end
    r = '0;
    if (holders == 1) begin
      r.letter_index = mfl_pkg::LETTER_W'(top_idx);
    end else begin
      r.is_tie = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfl_pkg::NUM_LETTERS; i++) tally[i] = '0;
      expected_modes.delete();
    end else begin
      // Accepted input item: count it, and close the word on the last mark
      if (in_valid && !in_stall) begin
        tally_byte(in_data.char_code);
        if (in_data.is_last) begin
          expected_modes.push_back(tally_mode());
          for (int i = 0; i < mfl_pkg::NUM_LETTERS; i++) tally[i] = '0;
        end
      end
      // Accepted result item: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: letter_index %0d is_tie %0b",
                                    out_data.letter_index, out_data.is_tie));
        end else begin
          want = expected_modes.pop_front();
          if (out_data.letter_index !== want.letter_index) begin
            report_mismatch($sformatf("letter_index %0d, expected %0d",
                                      out_data.letter_index, want.letter_index));
          end
          if (out_data.is_tie !== want.is_tie) begin
            report_mismatch($sformatf("is_tie %0b, expected %0b",
                                      out_data.is_tie, want.is_tie));
          end
        end
      end
    end
    pending = expected_modes.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the most-frequent-letter finder: clock, reset, word
// stimulus and result-side stalls. Needs mfl_pkg, the block and letter_mode_checker.
module tb;

  // Narrow counters so that saturation is reached by ordinary words
  localparam int CNT_W        = 4;
  localparam int ITEM_TARGET  = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  mfl_pkg::mfl_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  mfl_pkg::mfl_out_t out_data;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  most_frequent_letter_finder #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  letter_mode_checker #(
    .CNT_W(CNT_W)
  ) checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, none in the quiet stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Offer one byte, with an occasional idle gap before it, until taken
  task automatic send_byte(input logic [7:0] c, input logic last);
    mfl_pkg::mfl_in_t item;
    int gap;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    item.char_code = c;
    item.is_last   = last;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending until every expected result has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Word over a small letter pool with mixed case, stray bytes and random length
  task automatic send_random_word();
    int len, pool, base, sel, letter;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 10) len = 1;
    else if (sel < 85) len = $urandom_range(2, 16);
    else len = $urandom_range(17, 48);
    pool = $urandom_range(1, 4);
    base = $urandom_range(0, mfl_pkg::NUM_LETTERS - pool);
    for (int k = 0; k < len; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        letter = base + $urandom_range(0, pool - 1);
      end else begin
        letter = $urandom_range(0, mfl_pkg::NUM_LETTERS - 1);
      end
      if ($urandom_range(0, 1)) c = 8'(int'(mfl_pkg::ASCII_UP_A) + letter);
      else c = 8'(int'(mfl_pkg::ASCII_LO_A) + letter);
      if (sel >= 85) c = 8'($urandom_range(0, 255));
      send_byte(c, k == len - 1);
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty words made of the lowest and highest byte
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Bytes just outside both letter ranges, then a lone 'a'
    send_byte(8'd64, 1'b0);
    send_byte(8'd91, 1'b0);
    send_byte(8'd96, 1'b0);
    send_byte(8'd123, 1'b0);
    send_byte("a", 1'b1);
    // Top of both ranges fold into one letter
    send_byte("z", 1'b0);
    send_byte("Z", 1'b1);
    // Two letters once each tie
    send_byte("A", 1'b0);
    send_byte("b", 1'b1);
    // Counter driven past its top value
    repeat (16) send_byte("M", 1'b0);
    send_byte("m", 1'b1);
    wait_results();

    // Random words; long result hold-off, a drain pause and a quiet stretch
    while (items_sent < ITEM_TARGET) begin
      if (!hold_go && items_sent >= 300) hold_go = 1'b1;
      if (items_sent >= 800 && items_sent < 830) wait_results();
      quiet = (items_sent >= 1000 && items_sent < 1300);
      send_random_word();
    end
    quiet = 1'b0;
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
